/* hw/rtl/pdsa_pkg.sv */
// package for the packet descriptor slot allocator
// types, constants and result helpers shared by the interfaces and modules
// no dependencies
package pdsa_pkg;

   localparam int unsigned SLOTS      = 64;
   localparam int unsigned MAX_BYTES  = 4096;
   localparam int unsigned SLOT_W     = $clog2(SLOTS);
   localparam int unsigned COUNT_W    = $clog2(SLOTS + 1);
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned TIME_W     = 64;
   localparam int unsigned SLOT_OUT_W = 6;
   localparam int unsigned CSR_IDX_W  = 1;

   // request modes
   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_INVALID = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_BYTES = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] data_base;
      logic [DATA_W-1:0] data_area_bytes;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0] id;
      logic [DATA_W-1:0] size;
      logic [DATA_W-1:0] func;
      logic [TIME_W-1:0] stamp;
      logic [DATA_W-1:0] offset;
   } slot_entry_type;

   localparam int unsigned ENTRY_W = $bits(slot_entry_type);

   typedef struct packed {
      logic                we;
      logic [SLOT_W-1:0]   waddr;
      slot_entry_type      wdata;
      logic [SLOT_W-1:0]   raddr;
   } ram_cmd_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [DATA_W-1:0]     pkt_id;
      logic [SLOT_OUT_W-1:0] slot;
      logic [DATA_W-1:0]     pkt_offset;
      logic [DATA_W-1:0]     pkt_size;
      logic [DATA_W-1:0]     pkt_function;
      logic [TIME_W-1:0]     pkt_time;
      logic [COUNT_W-1:0]    live_count;
   } rsp_beat_type;

   // failed request: only status and live count are nonzero
   function automatic rsp_beat_type fail_beat(logic [1:0] st, logic [COUNT_W-1:0] cnt);
      rsp_beat_type b;
      b            = '0;
      b.status     = st;
      b.live_count = cnt;
      return b;
   endfunction

   function automatic rsp_beat_type ok_beat(slot_entry_type e, logic [SLOT_W-1:0] s,
                                            logic [COUNT_W-1:0] cnt);
      rsp_beat_type b;
      b.status       = STAT_OK;
      b.pkt_id       = e.id;
      b.slot         = SLOT_OUT_W'(s);
      b.pkt_offset   = e.offset;
      b.pkt_size     = e.size;
      b.pkt_function = e.func;
      b.pkt_time     = e.stamp;
      b.live_count   = cnt;
      return b;
   endfunction

endpackage

/* hw/rtl/pdsa_req_if.sv */
// request channel of the slot allocator: valid/ready plus request payload
// depends on pdsa_pkg
interface pdsa_req_if import pdsa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [DATA_W-1:0] req_size;
   logic [DATA_W-1:0] req_function;
   logic [DATA_W-1:0] req_id;
   logic [TIME_W-1:0] now_us;

   modport source (output valid, mode, req_size, req_function, req_id, now_us,
                   input ready);
   modport sink (input valid, mode, req_size, req_function, req_id, now_us,
                 output ready);
endinterface

/* hw/rtl/pdsa_rsp_if.sv */
// result channel of the slot allocator: valid/ready plus result payload
// depends on pdsa_pkg
interface pdsa_rsp_if import pdsa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [DATA_W-1:0]     pkt_id;
   logic [SLOT_OUT_W-1:0] slot;
   logic [DATA_W-1:0]     pkt_offset;
   logic [DATA_W-1:0]     pkt_size;
   logic [DATA_W-1:0]     pkt_function;
   logic [TIME_W-1:0]     pkt_time;
   logic [COUNT_W-1:0]    live_count;

   modport source (output valid, status, pkt_id, slot, pkt_offset, pkt_size,
                   pkt_function, pkt_time, live_count, input ready);
   modport sink (input valid, status, pkt_id, slot, pkt_offset, pkt_size,
                 pkt_function, pkt_time, live_count, output ready);
endinterface

/* hw/rtl/pdsa_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module pdsa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* hw/rtl/pdsa_ctrl.sv */
// sequencer of the slot allocator: valid bits, live count, id counter,
// slot scans over the descriptor ram and the result register
// depends on pdsa_pkg, pdsa_req_if, pdsa_rsp_if
module pdsa_ctrl import pdsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pdsa_req_if.sink             req_ch,
   pdsa_rsp_if.source           rsp_ch,
   input  cfg_type              cfg,
   output ram_cmd_type          ram_cmd,
   input  logic [ENTRY_W-1:0]   ram_rdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_FREE,
      S_CHECK,
      S_SCAN_ID,
      S_DONE
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   state_type            state_ff, state_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [DATA_W-1:0]    id_next_ff, id_next_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [SLOT_W-1:0]    pidx_ff, pidx_in;
   logic                 pend_ff, pend_in;
   logic [1:0]           mode_ff, mode_in;
   logic [DATA_W-1:0]    size_ff, size_in;
   logic [DATA_W-1:0]    func_ff, func_in;
   logic [DATA_W-1:0]    id_ff, id_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [DATA_W:0]      limit_ff, limit_in;
   logic [DATA_W:0]      off_ff, off_in;
   rsp_beat_type         res_ff, res_in;
   rsp_beat_type         out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   slot_entry_type       rd_entry;
   slot_entry_type       new_entry;
   logic [DATA_W:0]      area_sum;
   logic [DATA_W+1:0]    data_end;
   logic [DATA_W-1:0]    id_inc;

   assign rd_entry = slot_entry_type'(ram_rdata);
   assign area_sum = {1'b0, cfg.data_base} + {1'b0, cfg.data_area_bytes};
   assign data_end = {1'b0, off_ff} + (DATA_W + 2)'(size_ff);
   assign id_inc   = id_next_ff + DATA_W'(1);

   always_comb begin
      new_entry.id     = id_next_ff;
      new_entry.size   = size_ff;
      new_entry.func   = func_ff;
      new_entry.stamp  = now_ff;
      new_entry.offset = off_ff[DATA_W-1:0];
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_ff.status;
   assign rsp_ch.pkt_id       = out_ff.pkt_id;
   assign rsp_ch.slot         = out_ff.slot;
   assign rsp_ch.pkt_offset   = out_ff.pkt_offset;
   assign rsp_ch.pkt_size     = out_ff.pkt_size;
   assign rsp_ch.pkt_function = out_ff.pkt_function;
   assign rsp_ch.pkt_time     = out_ff.pkt_time;
   assign rsp_ch.live_count   = out_ff.live_count;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      id_next_in   = id_next_ff;
      idx_in       = idx_ff;
      pidx_in      = pidx_ff;
      pend_in      = pend_ff;
      mode_in      = mode_ff;
      size_in      = size_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      now_in       = now_ff;
      limit_in     = limit_ff;
      off_in       = off_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      ram_cmd.we    = 1'b0;
      ram_cmd.waddr = idx_ff;
      ram_cmd.wdata = new_entry;
      ram_cmd.raddr = idx_ff;

      // output register drains when the sink takes the beat
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               mode_in  = req_ch.mode;
               size_in  = req_ch.req_size;
               func_in  = req_ch.req_function;
               id_in    = req_ch.req_id;
               now_in   = req_ch.now_us;
               idx_in   = '0;
               pend_in  = 1'b0;
               // end of the data area, clipped to the 32-bit address space
               limit_in = area_sum[DATA_W] ? {1'b0, {DATA_W{1'b1}}} : area_sum;
               case (req_ch.mode)
                  MODE_ALLOC: begin
                     if (req_ch.req_size > DATA_W'(MAX_BYTES)) begin
                        res_in   = fail_beat(STAT_INVALID, count_ff);
                        state_in = S_DONE;
                     end else if (count_ff >= COUNT_W'(SLOTS)) begin
                        res_in   = fail_beat(STAT_FULL, count_ff);
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SCAN_FREE;
                     end
                  end
                  MODE_FREE, MODE_LOOKUP: begin
                     state_in = S_SCAN_ID;
                  end
                  default: begin
                     res_in   = fail_beat(STAT_INVALID, count_ff);
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN_FREE: begin
            if (!valid_ff[idx_ff]) begin
               off_in   = {1'b0, cfg.data_base}
                        + (DATA_W + 1)'(idx_ff) * (DATA_W + 1)'(MAX_BYTES);
               state_in = S_CHECK;
            end else if (idx_ff == LAST_SLOT) begin
               res_in   = fail_beat(STAT_FULL, count_ff);
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         S_CHECK: begin
            if (data_end > {1'b0, limit_ff}) begin
               res_in = fail_beat(STAT_FULL, count_ff);
            end else begin
               ram_cmd.we       = 1'b1;
               valid_in[idx_ff] = 1'b1;
               count_in         = count_ff + COUNT_W'(1);
               id_next_in       = (id_inc == '0) ? DATA_W'(1) : id_inc;
               res_in           = ok_beat(new_entry, idx_ff, count_in);
            end
            state_in = S_DONE;
         end

         S_SCAN_ID: begin
            // one address issued per cycle, its data checked in the cycle after
            pend_in = 1'b1;
            pidx_in = idx_ff;
            if (idx_ff != LAST_SLOT) begin
               idx_in = idx_ff + SLOT_W'(1);
            end
            if (pend_ff) begin
               if (valid_ff[pidx_ff] && rd_entry.id == id_ff) begin
                  if (mode_ff == MODE_FREE) begin
                     valid_in[pidx_ff] = 1'b0;
                     count_in          = count_ff - COUNT_W'(1);
                  end
                  res_in   = ok_beat(rd_entry, pidx_ff, count_in);
                  state_in = S_DONE;
               end else if (pidx_ff == LAST_SLOT) begin
                  res_in   = fail_beat(STAT_INVALID, count_ff);
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         id_next_ff   <= DATA_W'(1);
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         id_next_ff   <= id_next_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
         pidx_ff      <= pidx_in;
         mode_ff      <= mode_in;
         size_ff      <= size_in;
         func_ff      <= func_in;
         id_ff        <= id_in;
         now_ff       <= now_in;
         limit_ff     <= limit_in;
         off_ff       <= off_in;
         res_ff       <= res_in;
         out_ff       <= out_in;
      end
   end

endmodule

/* hw/rtl/packet_descriptor_slot_allocator.sv */
// top level of the packet descriptor slot allocator
// depends on pdsa_pkg, pdsa_req_if, pdsa_rsp_if, pdsa_ram, pdsa_ctrl
//
// usage:
//   req_ch carries one request beat: allocate, free by id or look up by id.
//   rsp_ch returns exactly one result beat per request, in request order.
//   csr_we/csr_index/csr_wdata write data_base (index 0) and
//   data_area_bytes (index 1); write them only while no request is in flight.
// sequencing:
//   one request at a time. the slot scan walks one descriptor per cycle
//   and ends at the lowest free slot for allocate, the lowest live match
//   for free/lookup, or slot 63 when no id matches. requests rejected on
//   size, count or mode skip the scan and go straight to the result beat.
//   the scan rate is set by the single read port of the descriptor ram.
// reset:
//   synchronous; clears all valid bits, the live count and the result
//   valid flag, and sets the next id to 1. the ram needs no clearing pass.
// backpressure:
//   the result sits in an output register; a new request is accepted while
//   it waits, and that request's result holds until the register frees up.
module packet_descriptor_slot_allocator import pdsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pdsa_req_if.sink             req_ch,
   pdsa_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   cfg_type              cfg_ff;
   ram_cmd_type          ram_cmd;
   logic [ENTRY_W-1:0]   ram_rdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_base       <= '0;
         cfg_ff.data_area_bytes <= DATA_W'(262144);
      end else if (csr_we) begin
         case (csr_index)
            CSR_DATA_BASE:  cfg_ff.data_base       <= csr_wdata;
            CSR_AREA_BYTES: cfg_ff.data_area_bytes <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // descriptor table: id, size, function, timestamp and data offset per slot
   pdsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_desc_ram (
      .clock (clock),
      .we    (ram_cmd.we),
      .waddr (ram_cmd.waddr),
      .wdata (ram_cmd.wdata),
      .raddr (ram_cmd.raddr),
      .rdata (ram_rdata)
   );

   // request sequencer with valid bits, counters and result register
   pdsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .cfg       (cfg_ff),
      .ram_cmd   (ram_cmd),
      .ram_rdata (ram_rdata)
   );

endmodule

/* tb/descriptor_table_checker.sv */
`timescale 1ns / 100ps
// result checker for the packet descriptor slot allocator: keeps a shadow descriptor table,
// predicts one result beat per request beat and compares the beats in order
// depends on pdsa_pkg, pdsa_req_if and pdsa_rsp_if
module descriptor_table_checker import pdsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pdsa_req_if                  req_ch,
   pdsa_rsp_if                  rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   pending,
   output logic [DATA_W-1:0]    next_id,
   output int                   ok_count,
   output int                   invalid_count,
   output int                   full_count,
   output int                   peak_live
);

   localparam int PRINT_CAP = 40;

   logic              shadow_live   [SLOTS];
   logic [DATA_W-1:0] shadow_id     [SLOTS];
   logic [DATA_W-1:0] shadow_size   [SLOTS];
   logic [DATA_W-1:0] shadow_func   [SLOTS];
   logic [TIME_W-1:0] shadow_stamp  [SLOTS];
   logic [DATA_W-1:0] shadow_offset [SLOTS];
   int                live_slots;
   logic [DATA_W-1:0] id_to_issue;
   logic [DATA_W-1:0] base_reg;
   logic [DATA_W-1:0] area_reg;
   rsp_beat_type      expected_results [$];
   int                errors;
   int                n_ok;
   int                n_invalid;
   int                n_full;
   int                n_peak;

   task automatic report_mismatch(input string what, input logic [63:0] got_val,
                                  input logic [63:0] want_val);
      errors++;
      if (errors <= PRINT_CAP)
         $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h",
                  $time, what, got_val, want_val);
   endtask

   // applies one request to the shadow table and returns the beat it should produce
   function automatic rsp_beat_type apply_request(input logic [1:0] mode,
                                                  input logic [DATA_W-1:0] size,
                                                  input logic [DATA_W-1:0] func,
                                                  input logic [DATA_W-1:0] id,
                                                  input logic [TIME_W-1:0] stamp);
      rsp_beat_type r;
      int           hit;
      int           idx;
      logic [63:0]  first_byte;
      logic [63:0]  end_byte;
      logic [63:0]  area_end;
      r        = '0;
      r.status = STAT_INVALID;
      hit      = -1;
      case (mode)
         MODE_ALLOC: begin
            if (size <= MAX_BYTES) begin
               for (idx = SLOTS - 1; idx >= 0; idx--)
                  if (!shadow_live[idx]) hit = idx;
               if (live_slots >= SLOTS || hit < 0) begin
                  r.status = STAT_FULL;
               end else begin
                  first_byte = {32'd0, base_reg} + 64'(hit) * 64'(MAX_BYTES);
                  end_byte   = first_byte + {32'd0, size};
                  area_end   = {32'd0, base_reg} + {32'd0, area_reg};
                  if (area_end > 64'hFFFF_FFFF) area_end = 64'hFFFF_FFFF;
                  if (end_byte > area_end) begin
                     r.status = STAT_FULL;
                  end else begin
                     shadow_live[hit]   = 1'b1;
                     shadow_id[hit]     = id_to_issue;
                     shadow_size[hit]   = size;
                     shadow_func[hit]   = func;
                     shadow_stamp[hit]  = stamp;
                     shadow_offset[hit] = first_byte[DATA_W-1:0];
                     id_to_issue        = id_to_issue + 1;
                     if (id_to_issue == '0) id_to_issue = 1;
                     live_slots++;
                     r.status = STAT_OK;
                  end
               end
            end
         end
         MODE_FREE, MODE_LOOKUP: begin
            for (idx = SLOTS - 1; idx >= 0; idx--)
               if (shadow_live[idx] && shadow_id[idx] == id) hit = idx;
            if (hit >= 0) r.status = STAT_OK;
         end
         default: ;
      endcase
      if (r.status == STAT_OK) begin
         r.pkt_id       = shadow_id[hit];
         r.slot         = SLOT_OUT_W'(hit);
         r.pkt_offset   = shadow_offset[hit];
         r.pkt_size     = shadow_size[hit];
         r.pkt_function = shadow_func[hit];
         r.pkt_time     = shadow_stamp[hit];
         // a freed slot reports its old contents, then goes away
         if (mode == MODE_FREE) begin
            shadow_live[hit] = 1'b0;
            live_slots--;
         end
      end
      r.live_count = COUNT_W'(live_slots);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      int           i;
      if (reset) begin
         for (i = 0; i < SLOTS; i++) shadow_live[i] = 1'b0;
         live_slots  = 0;
         id_to_issue = 1;
         base_reg    = '0;
         area_reg    = 32'd262144;
         expected_results.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status       = rsp_ch.status;
            got.pkt_id       = rsp_ch.pkt_id;
            got.slot         = rsp_ch.slot;
            got.pkt_offset   = rsp_ch.pkt_offset;
            got.pkt_size     = rsp_ch.pkt_size;
            got.pkt_function = rsp_ch.pkt_function;
            got.pkt_time     = rsp_ch.pkt_time;
            got.live_count   = rsp_ch.live_count;
            if (expected_results.size() == 0) begin
               report_mismatch("status of a beat with no request outstanding", got.status, 0);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.pkt_id !== want.pkt_id)
                  report_mismatch("pkt_id", got.pkt_id, want.pkt_id);
               if (got.slot !== want.slot)
                  report_mismatch("slot", got.slot, want.slot);
               if (got.pkt_offset !== want.pkt_offset)
                  report_mismatch("pkt_offset", got.pkt_offset, want.pkt_offset);
               if (got.pkt_size !== want.pkt_size)
                  report_mismatch("pkt_size", got.pkt_size, want.pkt_size);
               if (got.pkt_function !== want.pkt_function)
                  report_mismatch("pkt_function", got.pkt_function, want.pkt_function);
               if (got.pkt_time !== want.pkt_time)
                  report_mismatch("pkt_time", got.pkt_time, want.pkt_time);
               if (got.live_count !== want.live_count)
                  report_mismatch("live_count", got.live_count, want.live_count);
               case (want.status)
                  STAT_OK:   n_ok++;
                  STAT_FULL: n_full++;
                  default:   n_invalid++;
               endcase
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(apply_request(req_ch.mode, req_ch.req_size,
                                                     req_ch.req_function, req_ch.req_id,
                                                     req_ch.now_us));
            if (live_slots > n_peak) n_peak = live_slots;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DATA_BASE:  base_reg = csr_wdata;
               CSR_AREA_BYTES: area_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count    <= errors;
      pending       <= expected_results.size();
      next_id       <= id_to_issue;
      ok_count      <= n_ok;
      invalid_count <= n_invalid;
      full_count    <= n_full;
      peak_live     <= n_peak;
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// top of the slot allocator testbench: clock, reset, register settings, request beats,
// result backpressure and the verdict
// depends on pdsa_pkg, pdsa_req_if, pdsa_rsp_if, the allocator and descriptor_table_checker
module testbench;
   import pdsa_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;   // no operation, always rejected
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 125;
   localparam int SETTLE_CYCLES = 80;       // past the longest slot scan
   localparam int HOLD_CYCLES   = 400;      // long receiver hold-off so the block backs up
   localparam int CYCLE_LIMIT   = 800000;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   int                   fail_count;
   int                   pending;
   logic [DATA_W-1:0]    next_id;
   int                   ok_count;
   int                   invalid_count;
   int                   full_count;
   int                   peak_live;

   int                   cycle_count;
   int                   items_sent;
   int                   settings_used;
   int                   hold_asks;
   int                   holds_done;

   pdsa_req_if req_ch ();
   pdsa_rsp_if rsp_ch ();

   packet_descriptor_slot_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   descriptor_table_checker i_table_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .next_id       (next_id),
      .ok_count      (ok_count),
      .invalid_count (invalid_count),
      .full_count    (full_count),
      .peak_live     (peak_live)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results still outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
   end

   // offer one request beat and hold it until the block takes it
   task automatic offer(input logic [1:0] mode, input logic [DATA_W-1:0] size,
                        input logic [DATA_W-1:0] func, input logic [DATA_W-1:0] id,
                        input logic [TIME_W-1:0] stamp);
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= mode;
      req_ch.req_size     <= size;
      req_ch.req_function <= func;
      req_ch.req_id       <= id;
      req_ch.now_us       <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // drop valid and wait until every result beat is back and the scan has settled
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      // first let the checker's count take in the last accepted beat
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: stretches of different stall patterns, plus a long hold on request
   initial begin
      int style;
      int stretch;
      rsp_ch.ready <= 1'b0;
      forever begin
         style   = $urandom_range(0, 5);
         stretch = $urandom_range(10, 150);
         repeat (stretch) begin
            @(posedge clock);
            if (hold_asks != holds_done) begin
               // hold off long enough for the block to fill and stall its input
               rsp_ch.ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               holds_done++;
            end else begin
               case (style)
                  0, 1:    rsp_ch.ready <= 1'b1;
                  2:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                  3:       rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                  default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               endcase
            end
         end
      end
   end

   // request side and verdict
   initial begin
      logic [DATA_W-1:0] base_list [PHASES];
      logic [DATA_W-1:0] area_list [PHASES];
      logic [1:0]        mode;
      logic [DATA_W-1:0] size;
      logic [DATA_W-1:0] id;
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] hi;
      logic              fill;
      logic              held;
      int                p;
      int                n;
      int                r;
      int                burst;
      int                gap;
      int                fill_left;

      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_DATA_BASE;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.mode         <= MODE_ALLOC;
      req_ch.req_size     <= '0;
      req_ch.req_function <= '0;
      req_ch.req_id       <= '0;
      req_ch.now_us       <= '0;
      hold_asks           <= 0;

      // register settings per phase: reset values, then the extremes, then random ones
      base_list[0] = 32'd0;          area_list[0] = 32'd262144;
      base_list[1] = 32'd0;          area_list[1] = 32'd0;
      base_list[2] = 32'hFFFF_F000;  area_list[2] = 32'hFFFF_FFFF;
      base_list[3] = 32'd0;          area_list[3] = 32'hFFFF_FFFF;
      base_list[4] = 32'hFFFF_FFFF;  area_list[4] = 32'hFFFF_FFFF;
      base_list[5] = $urandom;
      area_list[5] = $urandom_range(4, 40) * MAX_BYTES + $urandom_range(0, MAX_BYTES - 1);
      base_list[6] = $urandom;       area_list[6] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed beats under the reset register values
      offer(MODE_LOOKUP, $urandom, $urandom, 32'd1, {$urandom, $urandom}); // empty table
      offer(MODE_FREE, $urandom, $urandom, 32'd0, {$urandom, $urandom});   // id zero
      offer(MODE_ALLOC, 32'd0, 32'd0, $urandom, 64'd0);                     // zero size, id 1
      offer(MODE_ALLOC, MAX_BYTES, 32'hFFFF_FFFF, $urandom, '1);            // largest size
      offer(MODE_ALLOC, MAX_BYTES + 1, $urandom, $urandom, {$urandom, $urandom}); // oversized
      offer(MODE_ALLOC, 32'hFFFF_FFFF, $urandom, $urandom, {$urandom, $urandom});
      offer(MODE_LOOKUP, '1, '1, 32'd2, '1);
      offer(MODE_LOOKUP, '0, '0, 32'd1, '0);
      offer(MODE_FREE, $urandom, $urandom, 32'd1, {$urandom, $urandom});  // frees slot 0
      offer(MODE_LOOKUP, $urandom, $urandom, 32'd1, {$urandom, $urandom}); // gone now
      offer(MODE_FREE, $urandom, $urandom, 32'd1, {$urandom, $urandom});   // double free
      offer(MODE_ALLOC, 32'd1, 32'h5A5A_A5A5, $urandom, {$urandom, $urandom}); // reuses slot 0
      offer(MODE_UNUSED, '1, '1, '1, '1);
      offer(MODE_LOOKUP, $urandom, $urandom, 32'hFFFF_FFFF, {$urandom, $urandom});
      offer(MODE_FREE, '0, '0, 32'd2, '0);
      offer(MODE_FREE, '0, '0, 32'd3, '0);
      offer(MODE_ALLOC, MAX_BYTES - 1, $urandom, $urandom, {$urandom, $urandom});

      // random phases; the first one opens with a long fill so the table runs full
      fill      = 1'b1;
      fill_left = 110;
      held      = 1'b0;
      for (p = 0; p < PHASES; p++) begin
         wait_idle();
         csr_we    <= 1'b1;
         csr_index <= CSR_DATA_BASE;
         csr_wdata <= base_list[p];
         @(posedge clock);
         csr_index <= CSR_AREA_BYTES;
         csr_wdata <= area_list[p];
         @(posedge clock);
         csr_we <= 1'b0;
         settings_used++;

         n = 0;
         while (n < PHASE_ITEMS) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            if (p == 0 && !held && n >= 40) begin
               // back-to-back beats while the receiver holds off
               held      = 1'b1;
               hold_asks <= hold_asks + 1;
               burst     = 24;
            end
            repeat (burst) begin
               // alternate fill and drain stretches so the table both fills and empties
               if (fill_left == 0) begin
                  fill      = ~fill;
                  fill_left = $urandom_range(40, 140);
               end
               fill_left--;
               r = $urandom_range(0, 99);
               if (r < 5)
                  mode = MODE_UNUSED;
               else if (fill)
                  mode = (r < 80) ? MODE_ALLOC : (r < 88) ? MODE_FREE : MODE_LOOKUP;
               else
                  mode = (r < 25) ? MODE_ALLOC : (r < 70) ? MODE_FREE : MODE_LOOKUP;

               r = $urandom_range(0, 99);
               if (r < 10)      size = '0;
               else if (r < 20) size = MAX_BYTES;
               else if (r < 25) size = MAX_BYTES + 1;
               else if (r < 32) size = $urandom;
               else             size = $urandom_range(1, MAX_BYTES - 1);

               // ids mostly from the recently issued range, so most frees and lookups hit
               lo = (next_id > 129) ? next_id - 128 : 32'd1;
               hi = (next_id > 1) ? next_id - 1 : 32'd1;
               r  = $urandom_range(0, 99);
               if (r < 75)      id = $urandom_range(hi, lo);
               else if (r < 85) id = next_id;
               else if (r < 92) id = '0;
               else             id = $urandom;

               offer(mode, size, $urandom, id, {$urandom, $urandom});
               n++;
            end
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      wait_idle();
      $display("run summary: %0d request beats under %0d register settings, %0d results checked",
               items_sent, settings_used + 1, ok_count + invalid_count + full_count);
      $display("run summary: %0d succeeded, %0d invalid or unknown id, %0d full, peak live %0d",
               ok_count, invalid_count, full_count, peak_live);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
